// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the multi-stack unit.
// Build with NO_ASSERTIONS defined to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed: label");

// When trig holds, cond must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

// ===== rtl/smms_pkg.sv =====
// Shared constants for the multi-stack unit: operation codes and field widths.
// No dependencies.
`default_nettype none

package smms_pkg;

    // Operation codes carried on s_tuser
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Fixed field widths of the stream words
    localparam int SEL_W   = 4;
    localparam int VALUE_W = 8;
    localparam int SIZE_W  = 6;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

endpackage

`default_nettype wire

// ===== rtl/shared_memory_multi_stack_unit.sv =====
// Top level of the multi-stack unit: NUM_STACKS stacks sharing one word memory.
// Depends on smms_pkg and assert_macros.svh.
//
// Usage
//   Input words arrive on s_tvalid/s_tready: s_tuser is the operation (push or
//   pop), s_tdata carries the stack selector and the word to push. Each input
//   word yields exactly one result word on m_tvalid/m_tready carrying the
//   popped word, the empty and full flags and the new size of the stack.
//   One operation runs at a time; s_tready returns high with its result word.
// Sequence
//   A pop passes EVAL, POP_RD and RESULT, a push into a stack with room EVAL,
//   PUSH and RESULT, an empty pop EVAL and RESULT. A push into a full region
//   scans neighbors one per cycle (at most NUM_STACKS - 1), moves the words in
//   between one per cycle, then writes the word.
// Reset
//   aresetn (synchronous, active low) spreads the stack bases evenly and
//   empties every stack. Memory contents are not cleared; no clearing pass.
// Stalls
//   The result waits in an output register while the next input word is taken;
//   a finished operation holds in its last state until that register is free.
`default_nettype none

`include "assert_macros.svh"

module shared_memory_multi_stack_unit #(
    parameter int NUM_STACKS = 16,
    parameter int MEM_DEPTH  = 64,
    parameter int DATA_WIDTH = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: [3:0] stack_sel, [11:4] push_value, [15:12] zero
    input  wire logic [smms_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: [0] kind
    input  wire logic                            s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: [7:0] pop_value, [8] empty_error, [9] full_error, [15:10] stack_size
    output logic [smms_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    localparam int PW = $clog2(NUM_STACKS);
    localparam int AW = $clog2(MEM_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_POP_RD,
        ST_SCAN_R,
        ST_SCAN_L,
        ST_SHIFT,
        ST_UPDATE,
        ST_PUSH,
        ST_RESULT
    } state_t;

    state_t                 state_reg;
    logic                   kind_reg;
    logic [PW-1:0]          sel_reg;
    logic [PW-1:0]          ptr_reg;
    logic [smms_pkg::VALUE_W-1:0] val_reg;
    logic                   oor_reg;
    logic [AW-1:0]          top_s_reg;
    logic [AW-1:0]          sh_addr_reg;
    logic [AW-1:0]          sh_end_reg;
    logic                   up_reg;
    logic                   pend_valid_reg;
    logic [AW-1:0]          pend_addr_reg;
    logic [smms_pkg::VALUE_W-1:0] pop_res_reg;
    logic                   empty_res_reg;
    logic                   full_res_reg;
    logic [smms_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tvalid_reg;

    logic [AW-1:0]          base_reg [NUM_STACKS];
    logic [AW-1:0]          top_reg  [NUM_STACKS];

    logic [DATA_WIDTH-1:0]  mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0]  rd_data_reg;

    logic                   s_fire;
    logic                   sel_in_range;
    logic [smms_pkg::SEL_W-1:0] s_sel;
    logic [NUM_STACKS-1:0]  slack;
    logic [AW-1:0]          top_at_ptr;
    logic [AW-1:0]          base_at_ptr;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [DATA_WIDTH-1:0]  mem_wd;
    logic [AW-1:0]          mem_ra;
    logic                   out_free;
    logic                   shifting;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign shifting = (state_reg == ST_SHIFT) || (state_reg == ST_UPDATE);

    assign s_sel        = s_tdata[smms_pkg::SEL_W-1:0];
    assign sel_in_range = (32'(s_sel) < NUM_STACKS);

    // One read port of the stack tables, steered by the scan pointer
    assign top_at_ptr  = top_reg[ptr_reg];
    assign base_at_ptr = base_reg[ptr_reg];

    // Each stack compares its top against the next base (or the last slot)
    always_comb begin
        for (int i = 0; i < NUM_STACKS; i++) begin
            if (i < NUM_STACKS - 1) begin
                slack[i] = (top_reg[i] < base_reg[(i + 1) % NUM_STACKS]);
            end else begin
                slack[i] = (top_reg[i] < AW'(MEM_DEPTH - 1));
            end
        end
    end

    // Memory port steering: each shift write lands in the cycle after its read
    assign mem_ra = (state_reg == ST_SHIFT) ? sh_addr_reg : top_at_ptr;
    assign mem_we = pend_valid_reg || (state_reg == ST_PUSH);
    assign mem_wa = pend_valid_reg ? pend_addr_reg : top_at_ptr + AW'(1);
    assign mem_wd = pend_valid_reg ? rd_data_reg : DATA_WIDTH'(val_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            ptr_reg        <= '0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                base_reg[i] <= AW'((i * MEM_DEPTH) / NUM_STACKS);
                top_reg[i]  <= AW'((i * MEM_DEPTH) / NUM_STACKS);
            end
        end else begin
            // drop the result word once taken, unless a new one loads below
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESULT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        kind_reg      <= s_tuser;
                        sel_reg       <= PW'(s_sel);
                        ptr_reg       <= PW'(s_sel);
                        val_reg       <= s_tdata[smms_pkg::SEL_W +: smms_pkg::VALUE_W];
                        oor_reg       <= !sel_in_range;
                        pop_res_reg   <= '0;
                        empty_res_reg <= 1'b0;
                        full_res_reg  <= 1'b0;
                        state_reg     <= sel_in_range ? ST_EVAL : ST_RESULT;
                    end
                end
                ST_EVAL: begin
                    top_s_reg <= top_at_ptr;
                    if (kind_reg == smms_pkg::KIND_POP) begin
                        if (top_at_ptr == base_at_ptr) begin
                            empty_res_reg <= 1'b1;
                            state_reg     <= ST_RESULT;
                        end else begin
                            // read of the top word was issued this cycle
                            state_reg <= ST_POP_RD;
                        end
                    end else if (slack[ptr_reg]) begin
                        state_reg <= ST_PUSH;
                    end else if (ptr_reg != PW'(NUM_STACKS - 1)) begin
                        ptr_reg   <= ptr_reg + PW'(1);
                        state_reg <= ST_SCAN_R;
                    end else if (ptr_reg == '0) begin
                        full_res_reg <= 1'b1;
                        state_reg    <= ST_RESULT;
                    end else begin
                        state_reg <= ST_SCAN_L;
                    end
                end
                ST_POP_RD: begin
                    pop_res_reg      <= smms_pkg::VALUE_W'(rd_data_reg);
                    top_reg[ptr_reg] <= top_at_ptr - AW'(1);
                    state_reg        <= ST_RESULT;
                end
                ST_SCAN_R: begin
                    if (slack[ptr_reg]) begin
                        // move words top_s+1 .. top[j] up by one, highest first
                        sh_addr_reg <= top_at_ptr;
                        sh_end_reg  <= top_s_reg + AW'(1);
                        up_reg      <= 1'b1;
                        state_reg   <= (top_at_ptr == top_s_reg) ? ST_UPDATE : ST_SHIFT;
                    end else if (ptr_reg == PW'(NUM_STACKS - 1)) begin
                        ptr_reg <= sel_reg;
                        if (sel_reg == '0) begin
                            full_res_reg <= 1'b1;
                            state_reg    <= ST_RESULT;
                        end else begin
                            state_reg <= ST_SCAN_L;
                        end
                    end else begin
                        ptr_reg <= ptr_reg + PW'(1);
                    end
                end
                ST_SCAN_L: begin
                    // pointer sits one above the candidate stack
                    if (slack[ptr_reg - PW'(1)]) begin
                        sh_addr_reg <= base_at_ptr + AW'(1);
                        sh_end_reg  <= top_s_reg;
                        up_reg      <= 1'b0;
                        state_reg   <= (base_at_ptr == top_s_reg) ? ST_UPDATE : ST_SHIFT;
                    end else if (ptr_reg == PW'(1)) begin
                        ptr_reg      <= sel_reg;
                        full_res_reg <= 1'b1;
                        state_reg    <= ST_RESULT;
                    end else begin
                        ptr_reg <= ptr_reg - PW'(1);
                    end
                end
                ST_SHIFT: begin
                    pend_valid_reg <= 1'b1;
                    pend_addr_reg  <= up_reg ? sh_addr_reg + AW'(1) : sh_addr_reg - AW'(1);
                    if (sh_addr_reg == sh_end_reg) begin
                        state_reg <= ST_UPDATE;
                    end else begin
                        sh_addr_reg <= up_reg ? sh_addr_reg - AW'(1) : sh_addr_reg + AW'(1);
                    end
                end
                ST_UPDATE: begin
                    // the last moved word, if any, lands this cycle; shift the bounds of the
                    // stacks between the addressed one and the scan hit
                    pend_valid_reg <= 1'b0;
                    for (int i = 0; i < NUM_STACKS; i++) begin
                        if (up_reg && (PW'(i) > sel_reg) && (PW'(i) <= ptr_reg)) begin
                            base_reg[i] <= base_reg[i] + AW'(1);
                            top_reg[i]  <= top_reg[i] + AW'(1);
                        end else if (!up_reg && (PW'(i) >= ptr_reg) && (PW'(i) <= sel_reg)) begin
                            base_reg[i] <= base_reg[i] - AW'(1);
                            top_reg[i]  <= top_reg[i] - AW'(1);
                        end
                    end
                    ptr_reg   <= sel_reg;
                    state_reg <= ST_PUSH;
                end
                ST_PUSH: begin
                    // word is written above the current top by the memory port
                    top_reg[ptr_reg] <= top_at_ptr + AW'(1);
                    state_reg        <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_tdata_reg[7:0]   <= pop_res_reg;
                        m_tdata_reg[8]     <= empty_res_reg;
                        m_tdata_reg[9]     <= full_res_reg;
                        m_tdata_reg[15:10] <= oor_reg ? '0
                                            : smms_pkg::SIZE_W'(top_at_ptr - base_at_ptr);
                        m_tvalid_reg       <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `ASSERT_ALWAYS(a_flags_exclusive, aclk, aresetn, !(m_tvalid && m_tdata[8] && m_tdata[9]))
    `ASSERT_ALWAYS(a_pend_in_shift, aclk, aresetn, !pend_valid_reg || shifting)
    `ASSERT_ALWAYS(a_top_not_below_base, aclk, aresetn, top_at_ptr >= base_at_ptr)
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_fire, !s_tready)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for shared_memory_multi_stack_unit: a queue-fed stream driver, a
// result monitor and a stack predictor run per accepted word. Depends on smms_pkg and the unit's RTL.

module testbench;

    localparam int CLK_PERIOD   = 10;
    localparam int NUM_STACKS   = 16;
    localparam int MEM_DEPTH    = 64;
    localparam int DATA_WIDTH   = 8;
    // Slot 0 is stack 0's exclusive base, so one slot is never usable.
    localparam int CAPACITY     = MEM_DEPTH - 1;
    localparam int RANDOM_OPS   = 850;
    localparam int IDLE_PERCENT = 27;
    // Worst push: scan every neighbor, move the whole memory, write the word.
    localparam int DRAIN_CYCLES = 2 * NUM_STACKS + MEM_DEPTH + 40;
    localparam int RUN_LIMIT    = 400_000;

    // One input word: which operation, on which stack, with which data.
    typedef struct packed {
        logic                         kind;
        logic [smms_pkg::SEL_W-1:0]   sel;
        logic [smms_pkg::VALUE_W-1:0] value;
    } stack_cmd_t;

    // One result word, split into its fields.
    typedef struct packed {
        logic [smms_pkg::VALUE_W-1:0] pop_value;
        logic                         empty_err;
        logic                         full_err;
        logic [smms_pkg::SIZE_W-1:0]  depth;
    } stack_reply_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic [smms_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [smms_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;

    stack_cmd_t   cmd_backlog[$];  // words still to be offered to the unit
    stack_reply_t reply_due[$];    // predicted results, oldest first

    int cycle_count    = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int error_count    = 0;

    // Predictor state: word memory, exclusive base and top slot of every stack.
    logic [smms_pkg::VALUE_W-1:0] slot_word  [MEM_DEPTH];
    int                           floor_slot [NUM_STACKS];
    int                           top_slot   [NUM_STACKS];

    // Stimulus bookkeeping: occupancy as the generator expects it to evolve.
    int planned_depth [NUM_STACKS];
    int planned_total = 0;

    shared_memory_multi_stack_unit #(
        .NUM_STACKS (NUM_STACKS),
        .MEM_DEPTH  (MEM_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),   // [3:0] stack_sel, [11:4] push_value, [15:12] zero
        .s_tuser  (s_tuser),   // [0] kind
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),   // [7:0] pop_value, [8] empty_error, [9] full_error,
                               // [15:10] stack_size
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Hold both sides free of idling for a stretch in the middle of the run.
    wire calm = (accepted_count >= 300) && (accepted_count < 420);

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A stack has room when its top is below the last slot of its region:
    // the next stack's base, or the last memory slot for the top stack.
    function automatic bit has_room(int s);
        int limit;
        limit = (s + 1 < NUM_STACKS) ? floor_slot[s + 1] : MEM_DEPTH - 1;
        return top_slot[s] < limit;
    endfunction

    // Free one slot above stack s: borrow from the nearest stack on the right
    // with room by moving everything in between up one slot; failing that,
    // borrow from the left by moving down. Report whether a slot was found.
    function automatic bit open_slot(int s);
        int j;
        int k;
        int left;
        for (j = s + 1; j < NUM_STACKS; j++) begin
            if (has_room(j)) begin
                for (k = top_slot[j]; k > floor_slot[s + 1]; k--) begin
                    if (k + 1 < MEM_DEPTH)
                        slot_word[k + 1] = slot_word[k];
                end
                for (k = s + 1; k <= j; k++) begin
                    floor_slot[k]++;
                    top_slot[k]++;
                end
                return 1'b1;
            end
        end
        for (j = s; j > 0; j--) begin
            left = j - 1;
            if (has_room(left)) begin
                for (k = floor_slot[left + 1]; k < top_slot[s]; k++) begin
                    if (k + 1 < MEM_DEPTH)
                        slot_word[k] = slot_word[k + 1];
                end
                for (k = left + 1; k <= s; k++) begin
                    floor_slot[k]--;
                    top_slot[k]--;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the predictor by one accepted word and return its result.
    function automatic stack_reply_t apply_stack_op(stack_cmd_t cmd);
        stack_reply_t r;
        int           s;
        bit           ok;
        r = '0;
        s = int'(cmd.sel);
        if (s >= NUM_STACKS)
            return r;
        if (cmd.kind == smms_pkg::KIND_PUSH) begin
            ok = has_room(s);
            if (!ok)
                ok = open_slot(s);
            if (ok) begin
                top_slot[s]++;
                if (top_slot[s] < MEM_DEPTH)
                    slot_word[top_slot[s]] = cmd.value;
            end else begin
                r.full_err = 1'b1;
            end
        end else if (top_slot[s] == floor_slot[s]) begin
            r.empty_err = 1'b1;
        end else begin
            r.pop_value = slot_word[top_slot[s]];
            top_slot[s]--;
        end
        r.depth = smms_pkg::SIZE_W'(top_slot[s] - floor_slot[s]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Queue one word and track how full each stack should become, so the
    // random part can steer toward full memory and back to empty.
    task automatic add_op(logic kind, int sel, logic [smms_pkg::VALUE_W-1:0] value);
        stack_cmd_t cmd;
        cmd.kind  = kind;
        cmd.sel   = smms_pkg::SEL_W'(sel);
        cmd.value = value;
        cmd_backlog.push_back(cmd);
        if (kind == smms_pkg::KIND_PUSH) begin
            if (planned_total < CAPACITY) begin
                planned_depth[sel]++;
                planned_total++;
            end
        end else if (planned_depth[sel] > 0) begin
            planned_depth[sel]--;
            planned_total--;
        end
    endtask

    // Pick a stack that holds words, if any stack does.
    function automatic int pick_loaded();
        int s;
        s = $urandom_range(0, NUM_STACKS - 1);
        if (planned_total == 0)
            return s;
        while (planned_depth[s] == 0)
            s = $urandom_range(0, NUM_STACKS - 1);
        return s;
    endfunction

    // Favor the edge stacks: pushing on stack 0 forces right shifts, on the
    // top stack left shifts.
    function automatic int pick_focus();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return NUM_STACKS - 1;
            default: return $urandom_range(0, NUM_STACKS - 1);
        endcase
    endfunction

    task automatic build_stimulus();
        int focus;
        int extra;
        int low_mark;
        int r;
        int n;
        int first_random;

        // Directed: empty pops at both edges, extreme data, overflow of the
        // bottom stack (shift right) and of the top stack (shift left).
        add_op(smms_pkg::KIND_POP,  0,              8'hFF);
        add_op(smms_pkg::KIND_POP,  NUM_STACKS - 1, 8'h00);
        add_op(smms_pkg::KIND_PUSH, 0,              8'h00);
        add_op(smms_pkg::KIND_PUSH, 0,              8'hFF);
        add_op(smms_pkg::KIND_PUSH, 0,              8'hA5);
        add_op(smms_pkg::KIND_PUSH, 0,              8'h5A);
        add_op(smms_pkg::KIND_PUSH, 0,              8'h3C);
        add_op(smms_pkg::KIND_PUSH, NUM_STACKS - 1, 8'h01);
        add_op(smms_pkg::KIND_PUSH, NUM_STACKS - 1, 8'h80);
        add_op(smms_pkg::KIND_PUSH, NUM_STACKS - 1, 8'h7F);
        add_op(smms_pkg::KIND_PUSH, NUM_STACKS - 1, 8'hC3);
        add_op(smms_pkg::KIND_POP,  NUM_STACKS - 1, 8'hFF);
        add_op(smms_pkg::KIND_POP,  0,              8'h00);
        add_op(smms_pkg::KIND_PUSH, 7,              8'h55);
        add_op(smms_pkg::KIND_POP,  7,              8'hAA);
        add_op(smms_pkg::KIND_POP,  7,              8'h0F);
        add_op(smms_pkg::KIND_PUSH, NUM_STACKS - 2, 8'hF0);
        add_op(smms_pkg::KIND_POP,  NUM_STACKS - 1, 8'h00);
        add_op(smms_pkg::KIND_POP,  0,              8'hFF);
        add_op(smms_pkg::KIND_PUSH, 1,              8'h99);

        // Random: rounds of fill to overflow, noise, then drain.
        first_random = cmd_backlog.size();
        while (cmd_backlog.size() - first_random < RANDOM_OPS) begin
            focus = pick_focus();
            extra = $urandom_range(1, 4);
            while (extra > 0) begin
                if (planned_total == CAPACITY)
                    extra--;
                if ($urandom_range(0, 99) < 5)
                    focus = pick_focus();
                r = $urandom_range(0, 99);
                if (r < 60)
                    add_op(smms_pkg::KIND_PUSH, focus, smms_pkg::VALUE_W'($urandom));
                else if (r < 85)
                    add_op(smms_pkg::KIND_PUSH, $urandom_range(0, NUM_STACKS - 1),
                           smms_pkg::VALUE_W'($urandom));
                else
                    add_op(smms_pkg::KIND_POP, pick_loaded(), smms_pkg::VALUE_W'($urandom));
            end

            n = $urandom_range(10, 30);
            repeat (n) begin
                add_op(logic'($urandom_range(0, 1)), $urandom_range(0, NUM_STACKS - 1),
                       smms_pkg::VALUE_W'($urandom));
            end

            low_mark = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            while (planned_total > low_mark) begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    add_op(smms_pkg::KIND_POP, pick_loaded(), smms_pkg::VALUE_W'($urandom));
                else if (r < 92)
                    add_op(smms_pkg::KIND_POP, $urandom_range(0, NUM_STACKS - 1),
                           smms_pkg::VALUE_W'($urandom));
                else
                    add_op(smms_pkg::KIND_PUSH, $urandom_range(0, NUM_STACKS - 1),
                           smms_pkg::VALUE_W'($urandom));
            end
        end

        // Trim the last round so the run keeps close to its planned length.
        while (cmd_backlog.size() > first_random + RANDOM_OPS)
            void'(cmd_backlog.pop_back());
    endtask

    // ------------------------------------------------------------------
    // Driver: offer backlog words, idle at random, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        stack_cmd_t next_cmd;
        stack_cmd_t taken;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // Predict from the word actually on the bus at the handshake.
            if (s_tvalid && s_tready) begin
                taken.kind  = s_tuser;
                taken.sel   = s_tdata[smms_pkg::SEL_W-1:0];
                taken.value = s_tdata[smms_pkg::SEL_W +: smms_pkg::VALUE_W];
                reply_due.push_back(apply_stack_op(taken));
                accepted_count <= accepted_count + 1;
            end
            // Advance only when the bus is free after this edge; otherwise hold.
            if (!s_tvalid || s_tready) begin
                if (cmd_backlog.size() > 0
                    && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    next_cmd = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_cmd.kind;
                    s_tdata  <= {{(smms_pkg::S_TDATA_W - smms_pkg::SEL_W
                                   - smms_pkg::VALUE_W){1'b0}},
                                 next_cmd.value, next_cmd.sel};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure: stall at random except in the calm stretch.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        stack_reply_t want;
        stack_reply_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.pop_value = m_tdata[7:0];
            got.empty_err = m_tdata[8];
            got.full_err  = m_tdata[9];
            got.depth     = m_tdata[15:10];
            if (reply_due.size() == 0) begin
                if (error_count < 10)
                    $display("result %0d arrived with nothing predicted: tdata=%h",
                             result_count, m_tdata);
                error_count++;
            end else begin
                want = reply_due.pop_front();
                if (got.pop_value !== want.pop_value || got.empty_err !== want.empty_err
                    || got.full_err !== want.full_err || got.depth !== want.depth) begin
                    if (error_count < 10)
                        $display({"result %0d mismatch: expected pop=%h empty=%b full=%b ",
                                  "size=%0d, got pop=%h empty=%b full=%b size=%0d"},
                                 result_count, want.pop_value, want.empty_err,
                                 want.full_err, want.depth, got.pop_value,
                                 got.empty_err, got.full_err, got.depth);
                    error_count++;
                end
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: build stimulus, release reset, wait for drain, report
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < MEM_DEPTH; i++)
            slot_word[i] = '0;
        for (int i = 0; i < NUM_STACKS; i++) begin
            floor_slot[i]    = (i * MEM_DEPTH) / NUM_STACKS;
            top_slot[i]      = floor_slot[i];
            planned_depth[i] = 0;
        end
        build_stimulus();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every word is accepted and every result has come back.
        while (cmd_backlog.size() > 0 || s_tvalid || reply_due.size() > 0)
            @(posedge aclk);
        // Leave room for any stray result word after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && reply_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < RUN_LIMIT)
            @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
